### rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/teb_pkg.sv
// Shared constants, types and helper functions of the edge bisection unit.
`default_nettype none
package teb_pkg;

    localparam int IMG_COLS      = 128;
    localparam int IMG_ROWS      = 128;
    localparam int FRACTION_BITS = 8;

    localparam int COORD_W     = 16;
    localparam int RGB_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int STORE_AW    = 14;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int THR_W       = 8;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

    localparam int SQ_W  = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int BSUM_W = CHAN_W + 2;
    localparam logic [SUM_W-1:0] ONE_SQ = SUM_W'(1) << (2 * FRACTION_BITS);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;        // store the pixel word
        logic load;      // take the query endpoints
        logic sel_near;  // read the pixel under the first point, else under the midpoint
        logic diff_en;   // capture absolute coordinate differences
        logic sqr_en;    // capture squared differences
        logic capt_mid;  // capture the midpoint pixel class
        logic step;      // move one of the points to the midpoint
        logic emit;      // present the result word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic far_apart;
    } t_stat;

    function automatic logic [COORD_W-1:0] mid(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COORD_W:1];
    endfunction

    // Round a coordinate to the nearest pixel, halves up, and clamp at the border.
    function automatic logic [31:0] to_pixel(input logic [COORD_W-1:0] v, input int limit);
        logic [COORD_W:0] r;
        logic [31:0]      p;
        r = {1'b0, v} + (COORD_W+1)'(1 << (FRACTION_BITS - 1));
        p = 32'(r >> FRACTION_BITS);
        if (p > 32'(limit - 1)) begin
            p = 32'(limit - 1);
        end
        return p;
    endfunction

    function automatic logic [STORE_AW-1:0] pixel_index(input logic [COORD_W-1:0] x,
                                                        input logic [COORD_W-1:0] y);
        logic [31:0] col;
        logic [31:0] row;
        logic [31:0] idx;
        col = to_pixel(x, IMG_COLS);
        row = to_pixel(y, IMG_ROWS);
        idx = row * 32'(IMG_COLS) + col;
        return idx[STORE_AW-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/threshold_edge_bisection_unit.sv
// Top level of the threshold edge bisection unit: controller, datapath and checks.
//
//  channel   direction  handshake           payload
//  command   in         start / busy        i_command, i_pixel_address, i_pixel_rgb,
//                                           i_start_x, i_start_y, i_end_x, i_end_y
//  result    out        o_done (strobe)     o_edge_x, o_edge_y
//  config    in         i_cfg_we            i_cfg_data (brightness threshold)
//
// A pixel write word is stored when it is accepted and leaves busy low. A query holds busy
// through one distance test per halving step plus the final one; each test runs the
// differences and midpoint read, then the squares and first-point read, then the test and
// point update. The image store has a single read port, so the two pixel reads of a test
// fall in separate steps. The result strobe lasts exactly one cycle; the receiver cannot
// stall it.
// Reset (synchronous, active low) clears the controller, the working points and
// sets the threshold to 128; the image store holds no reset value.
`default_nettype none
`include "assert_macros.svh"
module threshold_edge_bisection_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_command,
    input  wire logic [teb_pkg::STORE_AW-1:0]  i_pixel_address,
    input  wire logic [teb_pkg::RGB_W-1:0]     i_pixel_rgb,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_start_x,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_start_y,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_end_x,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_end_y,
    input  wire logic                          i_cfg_we,
    input  wire logic [teb_pkg::THR_W-1:0]     i_cfg_data,
    output logic                               o_done,
    output logic [teb_pkg::COORD_W-1:0]        o_edge_x,
    output logic [teb_pkg::COORD_W-1:0]        o_edge_y
);
    import teb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Accept words and sequence the loop: issue writes, reads, captures, the point update and the result.
    teb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    // Hold the image, the working points and the threshold; report the distance test.
    teb_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_pixel_address (i_pixel_address),
        .i_pixel_rgb     (i_pixel_rgb),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .o_stat          (stat),
        .o_done          (o_done),
        .o_edge_x        (o_edge_x),
        .o_edge_y        (o_edge_y)
    );

    // A query keeps the unit busy until its result goes out; a write does not.
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_command == CMD_QUERY, busy)
    `ASSERT_NEXT(a_write_free, i_clk, i_rst_n, start && !busy && i_command == CMD_WRITE, !busy)
    // A result strobe only ends a query and never repeats.
    `ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, cmd.emit, o_done && !busy)
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    // The points move only after the distance test finds them far apart.
    `ASSERT_SAME(a_step_far, i_clk, i_rst_n, cmd.step, stat.far_apart && busy)

endmodule
`default_nettype wire

### rtl/teb_ctrl.sv
// Sequencer of the edge bisection unit: accepts words and steps the halving loop.
`default_nettype none
module teb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_command,
    input  wire teb_pkg::t_stat i_stat,
    output teb_pkg::t_cmd      o_cmd,
    output logic               busy
);
    import teb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIFF = 4'b0010,
        ST_SQR  = 4'b0100,
        ST_CMP  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_command == CMD_QUERY) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIFF;
                end
                if (accept && i_command == CMD_WRITE) begin
                    o_cmd.wr = 1'b1;
                end
            end
            ST_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state       = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.sqr_en   = 1'b1;
                o_cmd.sel_near = 1'b1;
                o_cmd.capt_mid = 1'b1;
                n_state        = ST_CMP;
            end
            ST_CMP: begin
                if (i_stat.far_apart) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_DIFF;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### rtl/teb_dpath.sv
// Datapath of the edge bisection unit: image store, working points, distance and class.
`default_nettype none
module teb_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire teb_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [teb_pkg::THR_W-1:0]     i_cfg_data,
    input  wire logic [teb_pkg::STORE_AW-1:0]  i_pixel_address,
    input  wire logic [teb_pkg::RGB_W-1:0]     i_pixel_rgb,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_start_x,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_start_y,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_end_x,
    input  wire logic [teb_pkg::COORD_W-1:0]   i_end_y,
    output teb_pkg::t_stat                     o_stat,
    output logic                               o_done,
    output logic [teb_pkg::COORD_W-1:0]        o_edge_x,
    output logic [teb_pkg::COORD_W-1:0]        o_edge_y
);
    import teb_pkg::*;

    logic [RGB_W-1:0]    r_mem [STORE_DEPTH];
    logic [RGB_W-1:0]    r_rd_data;
    logic [STORE_AW-1:0] rd_addr;

    logic [THR_W-1:0]    r_thr;
    logic [COORD_W-1:0]  r_near_x, r_near_y, r_far_x, r_far_y;
    logic [COORD_W-1:0]  r_dx, r_dy;
    logic [SQ_W-1:0]     r_dx2, r_dy2;
    logic                r_bright_mid;
    logic                r_done;
    logic [COORD_W-1:0]  r_edge_x, r_edge_y;

    logic [COORD_W-1:0]  mid_x, mid_y;
    logic [BSUM_W-1:0]   chan_sum;
    logic [BSUM_W-1:0]   thr_x3;
    logic                bright;
    logic [SUM_W-1:0]    dist_sq;

    assign mid_x = mid(r_near_x, r_far_x);
    assign mid_y = mid(r_near_y, r_far_y);

    assign rd_addr = i_cmd.sel_near ? pixel_index(r_near_x, r_near_y)
                                    : pixel_index(mid_x, mid_y);

    // floor(sum/3) >= t is the same as sum >= 3t.
    assign chan_sum = BSUM_W'(r_rd_data[CHAN_W-1:0])
                    + BSUM_W'(r_rd_data[2*CHAN_W-1:CHAN_W])
                    + BSUM_W'(r_rd_data[3*CHAN_W-1:2*CHAN_W]);
    assign thr_x3   = BSUM_W'(r_thr) + BSUM_W'({r_thr, 1'b0});
    assign bright   = (chan_sum >= thr_x3);

    assign dist_sq          = SUM_W'(r_dx2) + SUM_W'(r_dy2);
    assign o_stat.far_apart = (dist_sq > ONE_SQ);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_pixel_address] <= i_pixel_rgb;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THR_RESET;
            r_done   <= 1'b0;
            r_near_x <= '0;
            r_near_y <= '0;
            r_far_x  <= '0;
            r_far_y  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_done <= i_cmd.emit;
            if (i_cmd.load) begin
                r_near_x <= i_start_x;
                r_near_y <= i_start_y;
                r_far_x  <= i_end_x;
                r_far_y  <= i_end_y;
            end else if (i_cmd.step) begin
                if (r_bright_mid == bright) begin
                    r_near_x <= mid_x;
                    r_near_y <= mid_y;
                end else begin
                    r_far_x <= mid_x;
                    r_far_y <= mid_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_dx <= (r_near_x > r_far_x) ? (r_near_x - r_far_x) : (r_far_x - r_near_x);
            r_dy <= (r_near_y > r_far_y) ? (r_near_y - r_far_y) : (r_far_y - r_near_y);
        end
        if (i_cmd.sqr_en) begin
            r_dx2 <= r_dx * r_dx;
            r_dy2 <= r_dy * r_dy;
        end
        if (i_cmd.capt_mid) begin
            r_bright_mid <= bright;
        end
        if (i_cmd.emit) begin
            r_edge_x <= mid_x;
            r_edge_y <= mid_y;
        end
    end

    assign o_done   = r_done;
    assign o_edge_x = r_edge_x;
    assign o_edge_y = r_edge_y;

endmodule
`default_nettype wire

### tb/tb_threshold_edge_bisection_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the threshold edge bisection unit: pixel writes and edge queries.
module tb_threshold_edge_bisection_unit;
    import teb_pkg::*;

    // Longest query: nine halving steps plus the final test.
    localparam int SETTLE_CYCLES = 40;
    // Least number of words per random phase, pixel fills included.
    localparam int PHASE_WORDS   = 90;
    localparam int ONE_PX        = 1 << FRACTION_BITS;
    localparam logic [33:0] PIXEL_SQ = 34'd1 << (2 * FRACTION_BITS);

    // One command word as seen on the input ports.
    typedef struct {
        logic                command;
        logic [STORE_AW-1:0] address;
        logic [RGB_W-1:0]    rgb;
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  ex;
        logic [COORD_W-1:0]  ey;
    } t_unit_word;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_edge_point;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_command;
    logic [STORE_AW-1:0] i_pixel_address;
    logic [RGB_W-1:0]    i_pixel_rgb;
    logic [COORD_W-1:0]  i_start_x;
    logic [COORD_W-1:0]  i_start_y;
    logic [COORD_W-1:0]  i_end_x;
    logic [COORD_W-1:0]  i_end_y;
    logic                i_cfg_we;
    logic [THR_W-1:0]    i_cfg_data;
    logic                o_done;
    logic [COORD_W-1:0]  o_edge_x;
    logic [COORD_W-1:0]  o_edge_y;

    // Mirror of the block: image contents, which entries hold data, and the threshold.
    logic [RGB_W-1:0] image_copy [STORE_DEPTH];
    bit               pixel_known [STORE_DEPTH];
    logic [THR_W-1:0] threshold_copy;

    // Crossings predicted for accepted queries, oldest first.
    t_edge_point pending_edges [$];
    t_edge_point due_edge;
    int          failures;
    int          words_sent;

    // Chance in percent that the sender keeps idling before a word, drawn again each time it idles.
    int idle_pct;

    // Current scene: a bright disk on a dark ground, in pixels.
    int scene_cx;
    int scene_cy;
    int scene_r;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    threshold_edge_bisection_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_pixel_address (i_pixel_address),
        .i_pixel_rgb     (i_pixel_rgb),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_edge_x        (o_edge_x),
        .o_edge_y        (o_edge_y)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Round a coordinate to the nearest pixel, halves up, and hold it inside the image.
    function automatic int nearest_pixel(input logic [COORD_W-1:0] v, input int limit);
        int p;
        p = (int'(v) + ONE_PX / 2) >> FRACTION_BITS;
        return (p > limit - 1) ? limit - 1 : p;
    endfunction

    function automatic int store_slot(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y);
        return (nearest_pixel(y, IMG_ROWS) * IMG_COLS + nearest_pixel(x, IMG_COLS))
               % STORE_DEPTH;
    endfunction

    // Bright when the truncated mean of the three channels reaches the threshold.
    function automatic bit is_lit(input int slot);
        logic [RGB_W-1:0] rgb;
        int               total;
        rgb   = image_copy[slot];
        total = rgb[7:0] + rgb[15:8] + rgb[23:16];
        return (total / 3) >= int'(threshold_copy);
    endfunction

    function automatic logic [COORD_W-1:0] halfway(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] total;
        total = a + b;
        return total[COORD_W:1];
    endfunction

    // Walk the bisection from (ax, ay) toward (bx, by) on the mirrored image.
    // Return the first store entry read that holds no data yet, or -1 once the
    // crossing is in pt.
    function automatic int trace_edge(input logic [COORD_W-1:0] ax,
                                      input logic [COORD_W-1:0] ay,
                                      input logic [COORD_W-1:0] bx,
                                      input logic [COORD_W-1:0] by,
                                      output t_edge_point pt);
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] mx;
        logic [COORD_W-1:0] my;
        logic [33:0]        dx;
        logic [33:0]        dy;
        int                 mid_slot;
        int                 near_slot;
        nx   = ax;
        ny   = ay;
        fx   = bx;
        fy   = by;
        pt.x = '0;
        pt.y = '0;
        forever begin
            dx = (nx > fx) ? nx - fx : fx - nx;
            dy = (ny > fy) ? ny - fy : fy - ny;
            if (dx * dx + dy * dy <= PIXEL_SQ) break;
            mx        = halfway(nx, fx);
            my        = halfway(ny, fy);
            mid_slot  = store_slot(mx, my);
            near_slot = store_slot(nx, ny);
            if (!pixel_known[mid_slot]) return mid_slot;
            if (!pixel_known[near_slot]) return near_slot;
            // Same side: the first point advances, else the second point pulls in.
            if (is_lit(mid_slot) == is_lit(near_slot)) begin
                nx = mx;
                ny = my;
            end else begin
                fx = mx;
                fy = my;
            end
        end
        pt.x = halfway(nx, fx);
        pt.y = halfway(ny, fy);
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Build a pixel write; fill the query fields with junk the block must ignore.
    function automatic t_unit_word pixel_write(input int slot, input logic [RGB_W-1:0] rgb);
        t_unit_word w;
        w.command = CMD_WRITE;
        w.address = STORE_AW'(slot);
        w.rgb     = rgb;
        w.sx      = COORD_W'($urandom);
        w.sy      = COORD_W'($urandom);
        w.ex      = COORD_W'($urandom);
        w.ey      = COORD_W'($urandom);
        return w;
    endfunction

    // Build an edge query; fill the write fields with junk the block must ignore.
    function automatic t_unit_word edge_query(input logic [COORD_W-1:0] sx,
                                              input logic [COORD_W-1:0] sy,
                                              input logic [COORD_W-1:0] ex,
                                              input logic [COORD_W-1:0] ey);
        t_unit_word w;
        w.command = CMD_QUERY;
        w.address = STORE_AW'($urandom);
        w.rgb     = RGB_W'($urandom);
        w.sx      = sx;
        w.sy      = sy;
        w.ex      = ex;
        w.ey      = ey;
        return w;
    endfunction

    function automatic void pick_scene();
        scene_cx = $urandom_range(20, IMG_COLS - 21);
        scene_cy = $urandom_range(20, IMG_ROWS - 21);
        scene_r  = $urandom_range(6, 40);
    endfunction

    // Pixel value for the scene: bright inside the disk, dark outside, some noise.
    // Channels sit on one level with up to 2 extra in the top channel, which the
    // truncated mean must drop.
    function automatic logic [RGB_W-1:0] scene_rgb(input int slot);
        int col;
        int row;
        int level;
        int top;
        bit inside_disk;
        col = slot % IMG_COLS;
        row = slot / IMG_COLS;
        if ($urandom_range(0, 99) < 15) return RGB_W'($urandom);
        inside_disk = (col - scene_cx) * (col - scene_cx) + (row - scene_cy) * (row - scene_cy)
                      < scene_r * scene_r;
        if (inside_disk || threshold_copy == '0) begin
            level = $urandom_range(threshold_copy, 255);
        end else begin
            level = $urandom_range(0, threshold_copy - 1);
        end
        top = level + $urandom_range(0, 2);
        if (top > 255) top = 255;
        return {CHAN_W'(top), CHAN_W'(level), CHAN_W'(level)};
    endfunction

    // Coordinate near a disk center, in fractional units.
    function automatic logic [COORD_W-1:0] disk_coord(input int centre);
        int v;
        v = centre * ONE_PX + $urandom_range(0, scene_r * ONE_PX) - scene_r * ONE_PX / 2;
        return (v < 0) ? '0 : COORD_W'(v);
    endfunction

    // Present one word at the falling edge, hold it until the block takes it, then
    // update the mirror. Leave start high so back-to-back words need no gap.
    task automatic send_word(input t_unit_word w);
        t_edge_point pt;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= w.command;
        i_pixel_address <= w.address;
        i_pixel_rgb     <= w.rgb;
        i_start_x       <= w.sx;
        i_start_y       <= w.sy;
        i_end_x         <= w.ex;
        i_end_y         <= w.ey;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        words_sent++;
        if (w.command == CMD_WRITE) begin
            image_copy[w.address]  = w.rgb;
            pixel_known[w.address] = 1'b1;
        end else if (trace_edge(w.sx, w.sy, w.ex, w.ey, pt) >= 0) begin
            $display("%0t: query word reads an unwritten pixel", $time);
            failures++;
        end else begin
            pending_edges.insert(pending_edges.size(), pt);
        end
    endtask

    // Write every pixel the query will read before sending it, so the block never
    // reads an entry that holds no data.
    task automatic issue_query(input logic [COORD_W-1:0] sx,
                               input logic [COORD_W-1:0] sy,
                               input logic [COORD_W-1:0] ex,
                               input logic [COORD_W-1:0] ey);
        t_edge_point scratch;
        int          hole;
        hole = trace_edge(sx, sy, ex, ey, scratch);
        while (hole >= 0) begin
            send_word(pixel_write(hole, scene_rgb(hole)));
            hole = trace_edge(sx, sy, ex, ey, scratch);
        end
        send_word(edge_query(sx, sy, ex, ey));
    endtask

    // Drop start, wait for every expected result, then let the block settle.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the threshold register while the block is idle.
    task automatic set_threshold(input logic [THR_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        threshold_copy = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Write words at the extremes of address and color, and alternating bit patterns.
    task automatic test_pixel_writes();
        send_word(pixel_write(0, '0));
        send_word(pixel_write(STORE_DEPTH - 1, '1));
        send_word(pixel_write(14'h2AAA, 24'hAAAAAA));
        send_word(pixel_write(14'h1555, 24'h555555));
    endtask

    // Equal endpoints, exactly one pixel apart, just inside and just past one pixel.
    task automatic test_short_segments();
        issue_query('0, '0, '0, '0);
        issue_query('1, '1, '1, '1);
        issue_query(16'd1000, 16'd1000, 16'd1256, 16'd1000);
        issue_query(16'd1000, 16'd1000, 16'd1181, 16'd1181);
        issue_query(16'd1000, 16'd1000, 16'd1257, 16'd1000);
    endtask

    // Points beyond the last row and column clamp to the border; halves round up.
    task automatic test_border_clamp();
        issue_query('0, '0, '1, '1);
        issue_query('0, '1, '1, '0);
        issue_query(16'h7F80, 16'h7F80, 16'hFFFF, 16'h0080);
        issue_query(16'h0080, 16'h007F, 16'h3000, 16'h3000);
    endtask

    // At zero every pixel is bright; at the top only full white is.
    task automatic test_threshold_extremes();
        set_threshold('0);
        repeat (3) begin
            issue_query(disk_coord(scene_cx), disk_coord(scene_cy),
                        COORD_W'($urandom_range(0, IMG_COLS * ONE_PX - 1)),
                        COORD_W'($urandom_range(0, IMG_ROWS * ONE_PX - 1)));
        end
        set_threshold('1);
        repeat (3) begin
            issue_query(disk_coord(scene_cx), disk_coord(scene_cy),
                        COORD_W'($urandom_range(0, IMG_COLS * ONE_PX - 1)),
                        COORD_W'($urandom_range(0, IMG_ROWS * ONE_PX - 1)));
        end
    endtask

    // Phases of random traffic, each with its own scene, threshold and idling.
    // The result side has no stall, so only the sender idles.
    task automatic test_random_traffic();
        int                 phase_idle [4] = '{0, 73, 0, 37};
        logic [THR_W-1:0]   phase_thr;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        int                 kind;
        int                 phase_end;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       phase_thr = THR_RESET;
                2:       phase_thr = 8'd1;
                3:       phase_thr = 8'd254;
                5:       phase_thr = '0;
                6:       phase_thr = '1;
                default: phase_thr = THR_W'($urandom);
            endcase
            set_threshold(phase_thr);
            pick_scene();
            idle_pct  = phase_idle[phase % 4];
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind < 2) begin
                    // Overwrite a random pixel: noise on top of the scene.
                    send_word(pixel_write($urandom_range(0, STORE_DEPTH - 1),
                                          RGB_W'($urandom)));
                end else begin
                    if (kind == 2) begin
                        // Anywhere in the coordinate range, far past the border too.
                        sx = COORD_W'($urandom);
                        sy = COORD_W'($urandom);
                        ex = COORD_W'($urandom);
                        ey = COORD_W'($urandom);
                    end else if (kind == 3) begin
                        // Short segments around the one-pixel limit.
                        sx = COORD_W'($urandom_range(0, IMG_COLS * ONE_PX - 1));
                        sy = COORD_W'($urandom_range(0, IMG_ROWS * ONE_PX - 1));
                        ex = sx + COORD_W'($urandom_range(0, 300));
                        ey = sy + COORD_W'($urandom_range(0, 300));
                    end else begin
                        // From inside the disk to somewhere in the image.
                        sx = disk_coord(scene_cx);
                        sy = disk_coord(scene_cy);
                        ex = COORD_W'($urandom_range(0, IMG_COLS * ONE_PX - 1));
                        ey = COORD_W'($urandom_range(0, IMG_ROWS * ONE_PX - 1));
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        issue_query(sx, sy, ex, ey);
                    end else begin
                        issue_query(ex, ey, sx, sy);
                    end
                end
                // Now and then hold the sender until every result is back.
                if ($urandom_range(0, 39) == 0) drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: every strobe must match the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_edges.size() == 0) begin
                $display("%0t: result word (%0d, %0d) with no query waiting",
                         $time, o_edge_x, o_edge_y);
                failures++;
            end else begin
                due_edge = pending_edges.pop_front();
                if (o_edge_x !== due_edge.x) begin
                    $display("%0t: edge_x expected %0d, got %0d", $time, due_edge.x, o_edge_x);
                    failures++;
                end
                if (o_edge_y !== due_edge.y) begin
                    $display("%0t: edge_y expected %0d, got %0d", $time, due_edge.y, o_edge_y);
                    failures++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_WRITE;
        i_pixel_address = '0;
        i_pixel_rgb     = '0;
        i_start_x       = '0;
        i_start_y       = '0;
        i_end_x         = '0;
        i_end_y         = '0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        failures        = 0;
        words_sent      = 0;
        idle_pct        = 0;
        threshold_copy  = THR_RESET;
        pick_scene();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pixel_writes();
        test_short_segments();
        test_border_clamp();
        test_threshold_extremes();
        test_random_traffic();

        drain_results();
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #48_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### threshold_edge_bisection_unit.f
+incdir+rtl
rtl/teb_pkg.sv
rtl/teb_ctrl.sv
rtl/teb_dpath.sv
rtl/threshold_edge_bisection_unit.sv
tb/tb_threshold_edge_bisection_unit.sv
